/* rtl/core/hrig_pkg.sv */
// Shared types, widths and decode helpers for the halo region index generator.
`timescale 1ns / 1ps

package hrig_pkg;

  localparam int MAX_EDGE = 1024;

  localparam int REGION_W = 5;
  localparam int IDX_W    = 10;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int GRID_W   = 30;
  localparam int BUF_W    = 20;

  // clamped size, 1..MAX_EDGE
  localparam int NW = $clog2(MAX_EDGE + 1);
  // coordinate: input index or size-1
  localparam int CW = (IDX_W > $clog2(MAX_EDGE)) ? IDX_W : $clog2(MAX_EDGE);

  localparam int PY_W  = CW + NW;
  localparam int NXY_W = 2 * NW;
  localparam int PZ_W  = CW + 2 * NW;
  localparam int SXY_W = PY_W + 1;
  localparam int BP_W  = CW + NW + 1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [REGION_W-1:0] REGION_LAST = 5'd25;

  // per-axis digit codes
  localparam logic [1:0] DG_LO  = 2'd0;
  localparam logic [1:0] DG_RUN = 2'd1;
  localparam logic [1:0] DG_HI  = 2'd2;

  typedef struct packed {
    logic [1:0] dz;
    logic [1:0] dy;
    logic [1:0] dx;
  } digits_t;

  typedef struct packed {
    logic          ok;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] cz;
    logic [NW-1:0] ext_in;
    logic [NW-1:0] ext_out;
  } dec_t;

  function automatic logic [NW-1:0] clamp_size(input logic [CFG_W-1:0] s);
    logic [NW-1:0] r;
    if (s == '0) begin
      r = NW'(1);
    end else if (32'(s) > 32'(MAX_EDGE)) begin
      r = NW'(MAX_EDGE);
    end else begin
      r = NW'(s);
    end
    return r;
  endfunction

  // region code -> base-3 cell digits, centre cell skipped
  function automatic digits_t region_digits(input logic [REGION_W-1:0] region);
    digits_t d;
    case (region)
      5'd0:    d = '{dz: DG_LO,  dy: DG_LO,  dx: DG_LO};
      5'd1:    d = '{dz: DG_LO,  dy: DG_LO,  dx: DG_RUN};
      5'd2:    d = '{dz: DG_LO,  dy: DG_LO,  dx: DG_HI};
      5'd3:    d = '{dz: DG_LO,  dy: DG_RUN, dx: DG_LO};
      5'd4:    d = '{dz: DG_LO,  dy: DG_RUN, dx: DG_RUN};
      5'd5:    d = '{dz: DG_LO,  dy: DG_RUN, dx: DG_HI};
      5'd6:    d = '{dz: DG_LO,  dy: DG_HI,  dx: DG_LO};
      5'd7:    d = '{dz: DG_LO,  dy: DG_HI,  dx: DG_RUN};
      5'd8:    d = '{dz: DG_LO,  dy: DG_HI,  dx: DG_HI};
      5'd9:    d = '{dz: DG_RUN, dy: DG_LO,  dx: DG_LO};
      5'd10:   d = '{dz: DG_RUN, dy: DG_LO,  dx: DG_RUN};
      5'd11:   d = '{dz: DG_RUN, dy: DG_LO,  dx: DG_HI};
      5'd12:   d = '{dz: DG_RUN, dy: DG_RUN, dx: DG_LO};
      5'd13:   d = '{dz: DG_RUN, dy: DG_RUN, dx: DG_HI};
      5'd14:   d = '{dz: DG_RUN, dy: DG_HI,  dx: DG_LO};
      5'd15:   d = '{dz: DG_RUN, dy: DG_HI,  dx: DG_RUN};
      5'd16:   d = '{dz: DG_RUN, dy: DG_HI,  dx: DG_HI};
      5'd17:   d = '{dz: DG_HI,  dy: DG_LO,  dx: DG_LO};
      5'd18:   d = '{dz: DG_HI,  dy: DG_LO,  dx: DG_RUN};
      5'd19:   d = '{dz: DG_HI,  dy: DG_LO,  dx: DG_HI};
      5'd20:   d = '{dz: DG_HI,  dy: DG_RUN, dx: DG_LO};
      5'd21:   d = '{dz: DG_HI,  dy: DG_RUN, dx: DG_RUN};
      5'd22:   d = '{dz: DG_HI,  dy: DG_RUN, dx: DG_HI};
      5'd23:   d = '{dz: DG_HI,  dy: DG_HI,  dx: DG_LO};
      5'd24:   d = '{dz: DG_HI,  dy: DG_HI,  dx: DG_RUN};
      5'd25:   d = '{dz: DG_HI,  dy: DG_HI,  dx: DG_HI};
      default: d = '{dz: DG_LO,  dy: DG_LO,  dx: DG_LO};
    endcase
    return d;
  endfunction

endpackage

/* rtl/core/hrig_decode.sv */
// Region decode: per-axis coordinates and running extents for one request.
`timescale 1ns / 1ps

module hrig_decode (
  input  logic [hrig_pkg::REGION_W-1:0] region,
  input  logic [hrig_pkg::IDX_W-1:0]    outer_index,
  input  logic [hrig_pkg::IDX_W-1:0]    inner_index,
  input  logic [hrig_pkg::NW-1:0]       nx,
  input  logic [hrig_pkg::NW-1:0]       ny,
  input  logic [hrig_pkg::NW-1:0]       nz,
  output hrig_pkg::dec_t                dec
);

  hrig_pkg::digits_t           d;
  logic                        xr, yr, zr;
  logic [hrig_pkg::CW-1:0]     inner_c, outer_c;

  always_comb begin
    d       = hrig_pkg::region_digits(region);
    xr      = (d.dx == hrig_pkg::DG_RUN);
    yr      = (d.dy == hrig_pkg::DG_RUN);
    zr      = (d.dz == hrig_pkg::DG_RUN);
    inner_c = hrig_pkg::CW'(inner_index);
    outer_c = hrig_pkg::CW'(outer_index);

    dec.ok = (region <= hrig_pkg::REGION_LAST);

    // first running axis (x, y, z order) takes inner, later ones take outer
    case (d.dx)
      hrig_pkg::DG_RUN: dec.cx = inner_c;
      hrig_pkg::DG_HI:  dec.cx = hrig_pkg::CW'(nx - 1'b1);
      default:          dec.cx = '0;
    endcase
    case (d.dy)
      hrig_pkg::DG_RUN: dec.cy = xr ? outer_c : inner_c;
      hrig_pkg::DG_HI:  dec.cy = hrig_pkg::CW'(ny - 1'b1);
      default:          dec.cy = '0;
    endcase
    case (d.dz)
      hrig_pkg::DG_RUN: dec.cz = (xr || yr) ? outer_c : inner_c;
      hrig_pkg::DG_HI:  dec.cz = hrig_pkg::CW'(nz - 1'b1);
      default:          dec.cz = '0;
    endcase

    if (xr) begin
      dec.ext_in = nx;
    end else if (yr) begin
      dec.ext_in = ny;
    end else if (zr) begin
      dec.ext_in = nz;
    end else begin
      dec.ext_in = hrig_pkg::NW'(1);
    end

    // last running axis after the first sets the outer extent
    if ((xr || yr) && zr) begin
      dec.ext_out = nz;
    end else if (xr && yr) begin
      dec.ext_out = ny;
    end else begin
      dec.ext_out = hrig_pkg::NW'(1);
    end
  end

endmodule

/* rtl/core/halo_region_index_generator.sv */
// Top level: pipelined grid and packed-buffer address generator for halo exchange.
`timescale 1ns / 1ps

// Usage:
//   Configuration: write size_x/size_y/size_z (index 0/1/2) on the cfg_ channel
//   while no request is in flight. cfg_ready is always high. Sizes of 0 act as
//   1 and sizes above MAX_EDGE act as MAX_EDGE.
//   Requests: drive in_region, in_outer_index, in_inner_index with start high.
//   busy never rises, so a request is taken at every edge where start is high.
//   Results: out_valid strobes for one cycle with out_grid_index,
//   out_buffer_index and out_in_range. The receiver cannot stall; every result
//   appears exactly once, in request order.
//   Pipeline: a request passes through four register stages (decode, first
//   multiplies, z multiply, final add) and its result is registered at the
//   output. Throughput: one request per cycle, set by the pipeline with at most
//   one multiplier level per stage.
//   Reset (rst_n low, synchronous): sizes return to 1 and all stage valid bits
//   clear, so requests in flight are dropped.
//   Region codes above 25 give zero indices and in_range low.

module halo_region_index_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  logic [hrig_pkg::REGION_W-1:0]   in_region,
  input  logic [hrig_pkg::IDX_W-1:0]      in_outer_index,
  input  logic [hrig_pkg::IDX_W-1:0]      in_inner_index,
  // result channel
  output logic                            out_valid,
  output logic [hrig_pkg::GRID_W-1:0]     out_grid_index,
  output logic [hrig_pkg::BUF_W-1:0]      out_buffer_index,
  output logic                            out_in_range,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hrig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrig_pkg::CFG_W-1:0]      cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [hrig_pkg::CFG_W-1:0] size_x_r, size_y_r, size_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= hrig_pkg::CFG_W'(1);
      size_y_r <= hrig_pkg::CFG_W'(1);
      size_z_r <= hrig_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hrig_pkg::REG_SIZE_X: size_x_r <= cfg_data;
        hrig_pkg::REG_SIZE_Y: size_y_r <= cfg_data;
        hrig_pkg::REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  logic [hrig_pkg::NW-1:0] nx, ny, nz;
  assign nx = hrig_pkg::clamp_size(size_x_r);
  assign ny = hrig_pkg::clamp_size(size_y_r);
  assign nz = hrig_pkg::clamp_size(size_z_r);

  // The pipeline never stalls: the receiver has no back-pressure.
  assign busy = 1'b0;

  logic in_acc;
  assign in_acc = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: region decode
  // ---------------------------------------------------------------------------
  hrig_pkg::dec_t dec;

  hrig_decode u_decode (
    .region      (in_region),
    .outer_index (in_outer_index),
    .inner_index (in_inner_index),
    .nx          (nx),
    .ny          (ny),
    .nz          (nz),
    .dec         (dec)
  );

  logic                        v1_r;
  hrig_pkg::dec_t              dec1_r;
  logic [hrig_pkg::IDX_W-1:0]  inner1_r, outer1_r;
  logic [hrig_pkg::NW-1:0]     nx1_r, ny1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    dec1_r   <= dec;
    inner1_r <= in_inner_index;
    outer1_r <= in_outer_index;
    nx1_r    <= nx;
    ny1_r    <= ny;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: y product, x*y plane size, buffer address, range check
  // ---------------------------------------------------------------------------
  logic                          v2_r;
  logic                          ok2_r, rng2_r;
  logic [hrig_pkg::CW-1:0]       cx2_r, cz2_r;
  logic [hrig_pkg::PY_W-1:0]     py2_r, py2_nxt;
  logic [hrig_pkg::NXY_W-1:0]    nxy2_r, nxy2_nxt;
  logic [hrig_pkg::BP_W-1:0]     bp2_r, bp2_nxt;
  logic                          rng2_nxt;

  always_comb begin
    py2_nxt  = hrig_pkg::PY_W'(dec1_r.cy) * hrig_pkg::PY_W'(nx1_r);
    nxy2_nxt = hrig_pkg::NXY_W'(nx1_r) * hrig_pkg::NXY_W'(ny1_r);
    bp2_nxt  = hrig_pkg::BP_W'(outer1_r) * hrig_pkg::BP_W'(dec1_r.ext_in)
             + hrig_pkg::BP_W'(inner1_r);
    rng2_nxt = (hrig_pkg::BP_W'(inner1_r) < hrig_pkg::BP_W'(dec1_r.ext_in)) &&
               (hrig_pkg::BP_W'(outer1_r) < hrig_pkg::BP_W'(dec1_r.ext_out));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    ok2_r  <= dec1_r.ok;
    rng2_r <= rng2_nxt;
    cx2_r  <= dec1_r.cx;
    cz2_r  <= dec1_r.cz;
    py2_r  <= py2_nxt;
    nxy2_r <= nxy2_nxt;
    bp2_r  <= bp2_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: z product and x + y partial sum
  // ---------------------------------------------------------------------------
  logic                          v3_r;
  logic                          ok3_r, rng3_r;
  logic [hrig_pkg::PZ_W-1:0]     pz3_r, pz3_nxt;
  logic [hrig_pkg::SXY_W-1:0]    sxy3_r, sxy3_nxt;
  logic [hrig_pkg::BP_W-1:0]     bp3_r;

  always_comb begin
    pz3_nxt  = hrig_pkg::PZ_W'(cz2_r) * hrig_pkg::PZ_W'(nxy2_r);
    sxy3_nxt = hrig_pkg::SXY_W'(cx2_r) + hrig_pkg::SXY_W'(py2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    ok3_r  <= ok2_r;
    rng3_r <= rng2_r;
    pz3_r  <= pz3_nxt;
    sxy3_r <= sxy3_nxt;
    bp3_r  <= bp2_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: final add, bad-region zeroing, output registers
  // ---------------------------------------------------------------------------
  logic                          out_valid_r;
  logic [hrig_pkg::GRID_W-1:0]   grid_r, grid_nxt;
  logic [hrig_pkg::BUF_W-1:0]    buf_r, buf_nxt;
  logic                          rng_r, rng_nxt;

  always_comb begin
    grid_nxt = hrig_pkg::GRID_W'(hrig_pkg::PZ_W'(sxy3_r) + pz3_r);
    buf_nxt  = hrig_pkg::BUF_W'(bp3_r);
    rng_nxt  = rng3_r && ok3_r;
    if (!ok3_r) begin
      grid_nxt = '0;
      buf_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    grid_r <= grid_nxt;
    buf_r  <= buf_nxt;
    rng_r  <= rng_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_grid_index   = grid_r;
  assign out_buffer_index = buf_r;
  assign out_in_range     = rng_r;

`ifndef SYNTHESIS
  // every result traces back to an earlier accepted request
  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, 4))
    else $error("result strobe without matching request");

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##4 out_valid)
    else $error("request lost in pipeline");

  // a region code beyond the last one yields zero addresses and out of range
  a_bad_region_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_region, 4) > hrig_pkg::REGION_LAST)) |->
      (out_grid_index == '0 && out_buffer_index == '0 && !out_in_range))
    else $error("bad region produced nonzero result");
`endif

endmodule
